// ===== rtl/tspp_pkg.sv =====
// Shared types and constants for the transport stream packet parser.
package tspp_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam logic [7:0] PACKET_LENGTH_RESET = 8'd188;
  localparam logic [7:0] MIN_PACKET_LENGTH = 8'(HEADER_BYTES + 1);
  localparam logic [8:0] HEADER_LAST_POS = 9'(HEADER_BYTES - 1);

  typedef enum logic [15:0] {
    PH_IDLE     = 16'h0001,
    PH_HDR      = 16'h0002,
    PH_AFLEN    = 16'h0004,
    PH_AFFLAGS  = 16'h0008,
    PH_PCR      = 16'h0010,
    PH_OPCR     = 16'h0020,
    PH_SPLICE   = 16'h0040,
    PH_PRIVLEN  = 16'h0080,
    PH_PRIVSKIP = 16'h0100,
    PH_EXTLEN   = 16'h0200,
    PH_EXTFLAGS = 16'h0400,
    PH_LTW      = 16'h0800,
    PH_RATE     = 16'h1000,
    PH_SEAM     = 16'h2000,
    PH_AFTAIL   = 16'h4000,
    PH_PAYLOAD  = 16'h8000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_INFO      = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_TEI_DROP  = 3'd2,
    KIND_SCRAMBLED = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_e;

  // Subfield sizes inside the adaptation field and its extension.
  localparam logic [2:0] PCR_BYTES    = 3'd6;
  localparam logic [2:0] OPCR_BYTES   = 3'd6;
  localparam logic [2:0] SPLICE_BYTES = 3'd1;
  localparam logic [2:0] PRIV_BYTES   = 3'd1;
  localparam logic [2:0] EXT_BYTES    = 3'd1;
  localparam logic [2:0] LTW_BYTES    = 3'd2;
  localparam logic [2:0] RATE_BYTES   = 3'd3;
  localparam logic [2:0] SEAM_BYTES   = 3'd5;

  // Per-packet parser state.
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  byte_pos;
    logic [7:0]  skip;
    logic [8:0]  field_end;
    logic [8:0]  ext_end;
    logic [23:0] hdr;
    logic [18:0] flags;   // 18:11 length, 10:8 extension flags, 7:0 flag byte
    logic [47:0] pcr;
    logic [47:0] opcr;
    logic [7:0]  splice;
    logic [21:0] rate;
  } state_t;

  // One parsed result record.
  typedef struct packed {
    logic        emit;
    kind_e       kind;
    logic [12:0] packet_id;
    logic [3:0]  continuity;
    logic [3:0]  header_bits;
    logic [7:0]  af_flags;
    logic [7:0]  af_length;
    logic [47:0] pcr;
    logic [47:0] opcr;
    logic [7:0]  splice;
    logic [21:0] rate;
    logic [2:0]  ext_flags;
    logic [7:0]  payload;
  } result_t;

  // Phase decision of one step.
  typedef struct packed {
    phase_e     phase;
    logic [7:0] skip;
    logic       emit;
    kind_e      kind;
  } next_t;

endpackage

// ===== rtl/tspp_step.sv =====
// Next-state and result logic of the parser for one stream byte.
module tspp_step (
  input  tspp_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              packet_start_i,
  input  logic [7:0]        packet_length_i,
  output tspp_pkg::state_t  state_o,
  output tspp_pkg::result_t result_o
);

  function automatic tspp_pkg::next_t af_done(logic [7:0] skip, logic pay);
    tspp_pkg::next_t n;
    n.phase = pay ? tspp_pkg::PH_PAYLOAD : tspp_pkg::PH_IDLE;
    n.skip  = skip;
    n.emit  = 1'b1;
    n.kind  = tspp_pkg::KIND_INFO;
    return n;
  endfunction

  function automatic tspp_pkg::next_t malformed(logic [7:0] skip);
    tspp_pkg::next_t n;
    n.phase = tspp_pkg::PH_IDLE;
    n.skip  = skip;
    n.emit  = 1'b1;
    n.kind  = tspp_pkg::KIND_MALFORMED;
    return n;
  endfunction

  // Picks the next present adaptation subfield at or after the given stage.
  function automatic tspp_pkg::next_t af_next(logic [4:0] flags, logic [2:0] stage,
                                              logic [8:0] pos, logic [8:0] fend,
                                              logic [7:0] skip, logic pay);
    logic [4:0]       m;
    logic [2:0]       need;
    logic             hit;
    tspp_pkg::phase_e ph;
    tspp_pkg::next_t  n;
    m    = flags & (5'b11111 >> stage);
    hit  = 1'b1;
    need = tspp_pkg::PCR_BYTES;
    ph   = tspp_pkg::PH_PCR;
    priority if (m[4]) begin
      need = tspp_pkg::PCR_BYTES;
      ph   = tspp_pkg::PH_PCR;
    end else if (m[3]) begin
      need = tspp_pkg::OPCR_BYTES;
      ph   = tspp_pkg::PH_OPCR;
    end else if (m[2]) begin
      need = tspp_pkg::SPLICE_BYTES;
      ph   = tspp_pkg::PH_SPLICE;
    end else if (m[1]) begin
      need = tspp_pkg::PRIV_BYTES;
      ph   = tspp_pkg::PH_PRIVLEN;
    end else if (m[0]) begin
      need = tspp_pkg::EXT_BYTES;
      ph   = tspp_pkg::PH_EXTLEN;
    end else begin
      hit = 1'b0;
    end
    n.phase = tspp_pkg::PH_AFTAIL;
    n.skip  = skip;
    n.emit  = 1'b0;
    n.kind  = tspp_pkg::KIND_INFO;
    if (hit) begin
      if (pos + 9'(need) > fend) begin
        n = malformed(skip);
      end else begin
        n.phase = ph;
        n.skip  = 8'(need);
      end
    end else if (pos >= fend) begin
      n = af_done(skip, pay);
    end
    return n;
  endfunction

  // Same for the subfields of the adaptation extension.
  function automatic tspp_pkg::next_t ext_next(logic [2:0] flags, logic [1:0] stage,
                                               logic [8:0] pos, logic [8:0] eend,
                                               logic [8:0] fend, logic [7:0] skip,
                                               logic pay);
    logic [2:0]       m;
    logic [2:0]       need;
    logic             hit;
    tspp_pkg::phase_e ph;
    tspp_pkg::next_t  n;
    m    = flags & (3'b111 >> stage);
    hit  = 1'b1;
    need = tspp_pkg::LTW_BYTES;
    ph   = tspp_pkg::PH_LTW;
    priority if (m[2]) begin
      need = tspp_pkg::LTW_BYTES;
      ph   = tspp_pkg::PH_LTW;
    end else if (m[1]) begin
      need = tspp_pkg::RATE_BYTES;
      ph   = tspp_pkg::PH_RATE;
    end else if (m[0]) begin
      need = tspp_pkg::SEAM_BYTES;
      ph   = tspp_pkg::PH_SEAM;
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      if (pos + 9'(need) > eend) begin
        n = malformed(skip);
      end else begin
        n.phase = ph;
        n.skip  = 8'(need);
        n.emit  = 1'b0;
        n.kind  = tspp_pkg::KIND_INFO;
      end
    end else begin
      n = af_next(5'b00000, 3'd5, pos, fend, skip, pay);
    end
    return n;
  endfunction

  tspp_pkg::state_t nxt;
  tspp_pkg::next_t  nx;
  logic [7:0]       len;
  logic [8:0]       last;
  logic [8:0]       pos;
  logic [8:0]       pos_plus_b;
  logic [7:0]       skip_dec;
  logic [23:0]      hdr_new;
  logic             pay;
  logic [7:0]       b1;
  logic [7:0]       b2;
  logic [7:0]       b3;
  logic             is_info;

  assign len        = (packet_length_i < tspp_pkg::MIN_PACKET_LENGTH) ?
                      tspp_pkg::MIN_PACKET_LENGTH : packet_length_i;
  assign last       = {1'b0, len} - 9'd1;
  assign pos        = {1'b0, state_i.byte_pos} + 9'd1;
  assign pos_plus_b = pos + {1'b0, data_byte_i};
  assign skip_dec   = (state_i.skip == 8'd0) ? 8'd0 : state_i.skip - 8'd1;
  assign hdr_new    = {state_i.hdr[15:0], data_byte_i};
  assign pay        = state_i.hdr[4];

  always_comb begin
    nxt        = state_i;
    nx.phase   = state_i.phase;
    nx.skip    = state_i.skip;
    nx.emit    = 1'b0;
    nx.kind    = tspp_pkg::KIND_INFO;
    if (packet_start_i) begin
      nxt       = '0;
      nxt.phase = tspp_pkg::PH_HDR;
      nx.phase  = tspp_pkg::PH_HDR;
      nx.skip   = 8'd0;
    end else if (state_i.phase != tspp_pkg::PH_IDLE) begin
      unique case (state_i.phase)
        tspp_pkg::PH_HDR: begin
          nxt.hdr = hdr_new;
          if (pos >= tspp_pkg::HEADER_LAST_POS) begin
            priority if (hdr_new[23]) begin
              nx.phase = tspp_pkg::PH_IDLE;
              nx.emit  = 1'b1;
              nx.kind  = tspp_pkg::KIND_TEI_DROP;
            end else if (hdr_new[7:6] != 2'b00) begin
              nx.phase = tspp_pkg::PH_IDLE;
              nx.emit  = 1'b1;
              nx.kind  = tspp_pkg::KIND_SCRAMBLED;
            end else if (hdr_new[5]) begin
              nx.phase = tspp_pkg::PH_AFLEN;
            end else begin
              nx = af_done(state_i.skip, hdr_new[4]);
            end
          end
        end
        tspp_pkg::PH_AFLEN: begin
          nxt.field_end    = pos_plus_b;
          nxt.flags[18:11] = data_byte_i;
          priority if (pos_plus_b > last) begin
            nx = malformed(state_i.skip);
          end else if (data_byte_i == 8'd0) begin
            nx = af_done(state_i.skip, pay);
          end else begin
            nx.phase = tspp_pkg::PH_AFFLAGS;
          end
        end
        tspp_pkg::PH_AFFLAGS: begin
          nxt.flags[7:0] = data_byte_i;
          nx = af_next(data_byte_i[4:0], 3'd0, pos, state_i.field_end, state_i.skip, pay);
        end
        tspp_pkg::PH_PCR: begin
          nxt.pcr = {state_i.pcr[39:0], data_byte_i};
          nx.skip = skip_dec;
          if (skip_dec == 8'd0) begin
            nx = af_next(state_i.flags[4:0], 3'd1, pos, state_i.field_end, skip_dec, pay);
          end
        end
        tspp_pkg::PH_OPCR: begin
          nxt.opcr = {state_i.opcr[39:0], data_byte_i};
          nx.skip  = skip_dec;
          if (skip_dec == 8'd0) begin
            nx = af_next(state_i.flags[4:0], 3'd2, pos, state_i.field_end, skip_dec, pay);
          end
        end
        tspp_pkg::PH_SPLICE: begin
          nxt.splice = data_byte_i;
          nx = af_next(state_i.flags[4:0], 3'd3, pos, state_i.field_end, state_i.skip, pay);
        end
        tspp_pkg::PH_PRIVLEN: begin
          // The length byte itself does not count toward the skipped span.
          priority if (pos_plus_b > state_i.field_end) begin
            nx = malformed(state_i.skip);
          end else if (data_byte_i == 8'd0) begin
            nx = af_next(state_i.flags[4:0], 3'd4, pos, state_i.field_end,
                         state_i.skip, pay);
          end else begin
            nx.skip  = data_byte_i;
            nx.phase = tspp_pkg::PH_PRIVSKIP;
          end
        end
        tspp_pkg::PH_PRIVSKIP: begin
          nx.skip = skip_dec;
          if (skip_dec == 8'd0) begin
            nx = af_next(state_i.flags[4:0], 3'd4, pos, state_i.field_end, skip_dec, pay);
          end
        end
        tspp_pkg::PH_EXTLEN: begin
          nxt.ext_end = pos_plus_b;
          priority if (pos_plus_b > state_i.field_end) begin
            nx = malformed(state_i.skip);
          end else if (data_byte_i == 8'd0) begin
            nx = af_next(state_i.flags[4:0], 3'd5, pos, state_i.field_end,
                         state_i.skip, pay);
          end else begin
            nx.phase = tspp_pkg::PH_EXTFLAGS;
          end
        end
        tspp_pkg::PH_EXTFLAGS: begin
          nxt.flags[10:8] = data_byte_i[7:5];
          nx = ext_next(data_byte_i[7:5], 2'd0, pos, state_i.ext_end, state_i.field_end,
                        state_i.skip, pay);
        end
        tspp_pkg::PH_LTW: begin
          nx.skip = skip_dec;
          if (skip_dec == 8'd0) begin
            nx = ext_next(state_i.flags[10:8], 2'd1, pos, state_i.ext_end,
                          state_i.field_end, skip_dec, pay);
          end
        end
        tspp_pkg::PH_RATE: begin
          nxt.rate = {state_i.rate[13:0], data_byte_i};
          nx.skip  = skip_dec;
          if (skip_dec == 8'd0) begin
            nx = ext_next(state_i.flags[10:8], 2'd2, pos, state_i.ext_end,
                          state_i.field_end, skip_dec, pay);
          end
        end
        tspp_pkg::PH_SEAM: begin
          nx.skip = skip_dec;
          if (skip_dec == 8'd0) begin
            nx = ext_next(state_i.flags[10:8], 2'd3, pos, state_i.ext_end,
                          state_i.field_end, skip_dec, pay);
          end
        end
        tspp_pkg::PH_AFTAIL: begin
          if (pos >= state_i.field_end) begin
            nx = af_done(state_i.skip, pay);
          end
        end
        tspp_pkg::PH_PAYLOAD: begin
          nx.emit = 1'b1;
          nx.kind = tspp_pkg::KIND_PAYLOAD;
        end
        default: begin
          nx.phase = tspp_pkg::PH_IDLE;
        end
      endcase
      nxt.byte_pos = pos[7:0];
      if (pos >= last) begin
        nx.phase = tspp_pkg::PH_IDLE;
      end
      nxt.phase = nx.phase;
      nxt.skip  = nx.skip;
    end
  end

  assign state_o = nxt;

  assign b1      = nxt.hdr[23:16];
  assign b2      = nxt.hdr[15:8];
  assign b3      = nxt.hdr[7:0];
  assign is_info = (nx.kind == tspp_pkg::KIND_INFO);

  always_comb begin
    result_o.emit        = nx.emit;
    result_o.kind        = nx.kind;
    result_o.packet_id   = {b1[4:0], b2};
    result_o.continuity  = b3[3:0];
    result_o.header_bits = {b1[6], b1[5], b3[5:4]};
    result_o.af_flags    = is_info ? nxt.flags[7:0] : 8'd0;
    result_o.af_length   = is_info ? nxt.flags[18:11] : 8'd0;
    result_o.pcr         = is_info ? nxt.pcr : 48'd0;
    result_o.opcr        = is_info ? nxt.opcr : 48'd0;
    result_o.splice      = is_info ? nxt.splice : 8'd0;
    result_o.rate        = is_info ? nxt.rate : 22'd0;
    result_o.ext_flags   = is_info ? nxt.flags[10:8] : 3'd0;
    result_o.payload     = (nx.kind == tspp_pkg::KIND_PAYLOAD) ? data_byte_i : 8'd0;
  end

endmodule

// ===== rtl/transport_stream_packet_parser_core.sv =====
// Top level of the byte-serial transport stream packet parser.
//
// The parser takes a transport stream one byte per transaction, with
// packet_start_i marking each packet's first (sync) byte, and accepts a new
// byte in every clock cycle: the parse logic is combinational, and a byte's
// result, if any, appears on the output register in the next cycle.
// The only thing that slows the input is a stalled output: in_ready_o is low
// exactly while a result is held and out_ready_i is low. From the four header
// bytes and the adaptation field (flag byte, raw PCR and OPCR, splice
// countdown, private data, and the extension with its piecewise rate) one
// info record (kind 0) is produced when the adaptation field ends, or on the
// last header byte when there is none; after that every payload byte is passed
// as kind 1 until the configured packet length. A transport error or a
// scrambled packet gives one drop record (kinds 2 and 3) on the last header
// byte; a subfield that runs past the end of its enclosing field gives one
// malformed record (kind 4). In both cases the rest of the packet is ignored.
// Bytes before the first packet start are ignored, and a packet start in the
// middle of a packet silently abandons it. The packet length register may be
// written only while no transaction is in flight; values below five act as
// five, and a change in the middle of a packet ends that packet at the first
// byte whose position reaches the new last position.
module transport_stream_packet_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: packet length in bytes, header included.
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  // Stream input.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               packet_start_i,
  // Result output.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [12:0]        packet_id_o,
  output logic [3:0]         continuity_o,
  output logic [3:0]         header_bits_o,
  output logic [7:0]         adaptation_flags_o,
  output logic [7:0]         adaptation_length_o,
  output logic [47:0]        clock_reference_o,
  output logic [47:0]        original_clock_reference_o,
  output logic signed [7:0]  splice_count_o,
  output logic [21:0]        piecewise_rate_value_o,
  output logic [2:0]         extension_flags_o,
  output logic [7:0]         payload_byte_o
);

  // Packet length register.
  logic [7:0] packet_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_length_q <= tspp_pkg::PACKET_LENGTH_RESET;
    end else if (cfg_we_i) begin
      packet_length_q <= cfg_wdata_i;
    end
  end

  // The parser state is the stage register in front of the parse logic; the
  // output register behind it holds one finished record.
  tspp_pkg::state_t  state_q;
  tspp_pkg::state_t  state_d;
  tspp_pkg::result_t res;
  tspp_pkg::result_t out_q;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  tspp_step u_step (
    .state_i         (state_q),
    .data_byte_i     (data_byte_i),
    .packet_start_i  (packet_start_i),
    .packet_length_i (packet_length_q),
    .state_o         (state_d),
    .result_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= {tspp_pkg::PH_IDLE,
                  {($bits(tspp_pkg::state_t) - $bits(tspp_pkg::phase_e)){1'b0}}};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // A record leaves when taken; a new one can be loaded in the same cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && res.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o                = out_valid_q;
  assign kind_o                     = out_q.kind;
  assign packet_id_o                = out_q.packet_id;
  assign continuity_o               = out_q.continuity;
  assign header_bits_o              = out_q.header_bits;
  assign adaptation_flags_o         = out_q.af_flags;
  assign adaptation_length_o        = out_q.af_length;
  assign clock_reference_o          = out_q.pcr;
  assign original_clock_reference_o = out_q.opcr;
  assign splice_count_o             = signed'(out_q.splice);
  assign piecewise_rate_value_o     = out_q.rate;
  assign extension_flags_o          = out_q.ext_flags;
  assign payload_byte_o             = out_q.payload;

  // The parse phase must always be exactly one of the one-hot codes.
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q.phase))
    else $error("parse phase is not one-hot");

  // A record may only appear as the result of an accepted byte.
  a_out_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire))
    else $error("result appeared without an input transaction");

  // Payload bytes come only from the payload phase.
  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res.emit && res.kind == tspp_pkg::KIND_PAYLOAD
    |-> state_q.phase == tspp_pkg::PH_PAYLOAD)
    else $error("payload byte emitted outside the payload phase");

  // A packet start restarts header collection from position zero.
  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && packet_start_i
    |=> state_q.phase == tspp_pkg::PH_HDR && state_q.byte_pos == 8'd0)
    else $error("packet start did not restart the header");

  // Adaptation fields are blank in every record that is not an info record.
  a_af_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != tspp_pkg::KIND_INFO
    |-> out_q.af_flags == 8'd0 && out_q.pcr == 48'd0 && out_q.ext_flags == 3'd0)
    else $error("adaptation fields set in a non-info record");

endmodule
